FILE: rtl/stxenc_pkg.sv
// Package with constants, register indexes and the CRC-16 byte update for the frame encoder.
`timescale 1ns / 1ps

package stxenc_pkg;

  localparam int unsigned LEN_BITS = 16;
  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 64'd1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_BITS    = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] START_BYTE_RST  = 8'd2;
  localparam logic [7:0] END_BYTE_RST    = 8'd3;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

  typedef enum logic [1:0] {
    REG_START_BYTE  = 2'd0,
    REG_END_BYTE    = 2'd1,
    REG_MAX_PAYLOAD = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

FILE: rtl/stx_etx_frame_encoder_crc16.sv
// Top level of the STX/ETX frame encoder with length prefix and CRC-16 trailer.
// An item is registered in the input register at its transfer, and its results are loaded
// into the result buffer once the buffer is empty or is giving up its last result.
// Throughput: one input item per cycle while each item gives one result and the output does
// not stall; an item that gives N results holds the buffer for N transfers, one byte each.
// Reset (synchronous, active low) empties both stages, closes any open frame and restores
// the registers to start byte 2, end byte 3 and maximum payload 4096.
`timescale 1ns / 1ps

module stx_etx_frame_encoder_crc16
  import stxenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] frame_len
  input  logic [0:0]  in_tuser,   // [0] frame_start
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // [0] frame_end, [1] rejected
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  start_byte_r;
  logic [7:0]  end_byte_r;
  logic [15:0] max_payload_r;
  reg_idx_t    reg_idx;

  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_start_r;
  logic [15:0] s1_len_r;

  logic        in_frame_r, in_frame_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic [7:0]          res_byte_r [MAX_RESULTS];
  logic [7:0]          res_byte_nxt [MAX_RESULTS];
  logic [7:0]          shift_byte [MAX_RESULTS];
  logic [CNT_BITS-1:0] res_cnt_r, res_cnt_nxt;
  logic                res_fend_r, res_fend_nxt;
  logic                res_rej_r, res_rej_nxt;

  logic        take;
  logic        proc;
  logic        hdr;
  logic        drop;
  logic        reject;
  logic        tail;
  logic [31:0] len32;
  logic [15:0] len16;
  logic [15:0] cur_left;
  logic [15:0] new_left;
  logic [15:0] cur_crc;
  logic [15:0] new_crc;
  logic [7:0]  list_byte [MAX_RESULTS];
  logic [CNT_BITS-1:0] list_cnt;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= START_BYTE_RST;
      end_byte_r    <= END_BYTE_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_START_BYTE:  start_byte_r  <= pwdata[7:0];
        REG_END_BYTE:    end_byte_r    <= pwdata[7:0];
        REG_MAX_PAYLOAD: max_payload_r <= pwdata[15:0];
        REG_NONE: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_BYTE:  prdata = {24'h0, start_byte_r};
      REG_END_BYTE:    prdata = {24'h0, end_byte_r};
      REG_MAX_PAYLOAD: prdata = {16'h0, max_payload_r};
      REG_NONE:        prdata = 32'h0;
    endcase
  end

  // Handshake between the input register and the result buffer.
  assign out_tvalid = (res_cnt_r != '0);
  assign take       = out_tvalid && out_tready;
  assign proc       = s1_valid_r && ((res_cnt_r == '0) ||
                      ((res_cnt_r == CNT_BITS'(1)) && out_tready));
  assign in_tready  = !s1_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_tdata[7:0];
      s1_len_r   <= in_tdata[23:8];
      s1_start_r <= in_tuser[0];
    end
  end

  // Frame logic for the item in the input register.
  assign len32    = {16'h0, s1_len_r} & LEN_MASK;
  assign len16    = len32[15:0];
  assign hdr      = !in_frame_r && s1_start_r;
  assign drop     = !in_frame_r && !s1_start_r;
  assign reject   = hdr && ((len16 == 16'h0) || (len16 > max_payload_r));
  assign cur_left = hdr ? len16 : bytes_left_r;
  assign cur_crc  = hdr ? CRC_INIT : crc_r;
  assign new_crc  = crc16_byte(cur_crc, s1_data_r);
  assign new_left = (cur_left - 16'd1) & LEN_MASK[15:0];
  assign tail     = (new_left == 16'h0);

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      list_byte[i] = 8'h00;
    end
    list_cnt = '0;
    if (drop) begin
      list_cnt = '0;
    end else if (reject) begin
      list_cnt = CNT_BITS'(1);
    end else if (hdr) begin
      list_byte[0] = start_byte_r;
      list_byte[1] = len32[7:0];
      list_byte[2] = len32[15:8];
      list_byte[3] = len32[23:16];
      list_byte[4] = len32[31:24];
      list_byte[5] = s1_data_r;
      list_byte[6] = new_crc[7:0];
      list_byte[7] = new_crc[15:8];
      list_byte[8] = end_byte_r;
      list_cnt     = tail ? CNT_BITS'(9) : CNT_BITS'(6);
    end else begin
      list_byte[0] = s1_data_r;
      list_byte[1] = new_crc[7:0];
      list_byte[2] = new_crc[15:8];
      list_byte[3] = end_byte_r;
      list_cnt     = tail ? CNT_BITS'(4) : CNT_BITS'(1);
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    if (proc && !drop && !reject) begin
      in_frame_nxt   = !tail;
      bytes_left_nxt = new_left;
      crc_nxt        = tail ? CRC_INIT : new_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bytes_left_r <= 16'h0;
      crc_r        <= CRC_INIT;
    end else begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // Result buffer: entry zero is on the output and the rest shift down per transfer.
  always_comb begin
    for (int i = 0; i < MAX_RESULTS - 1; i++) begin
      shift_byte[i] = res_byte_r[i+1];
    end
    shift_byte[MAX_RESULTS-1] = 8'h00;
  end

  always_comb begin
    res_byte_nxt = res_byte_r;
    res_cnt_nxt  = res_cnt_r;
    res_fend_nxt = res_fend_r;
    res_rej_nxt  = res_rej_r;
    if (proc) begin
      res_byte_nxt = list_byte;
      res_cnt_nxt  = list_cnt;
      res_fend_nxt = !reject && tail;
      res_rej_nxt  = reject;
    end else if (take) begin
      res_byte_nxt = shift_byte;
      res_cnt_nxt  = res_cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_byte_r <= res_byte_nxt;
    res_fend_r <= res_fend_nxt;
    res_rej_r  <= res_rej_nxt;
  end

  assign out_tdata    = res_byte_r[0];
  assign out_tlast    = (res_cnt_r == CNT_BITS'(1));
  assign out_tuser[0] = out_tlast && res_fend_r;
  assign out_tuser[1] = res_rej_r;

`ifndef ASSERT_OFF
  a_frame_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (bytes_left_r != 16'h0))
    else $error("Open frame with no payload bytes left.");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> ((res_cnt_r == '0) || ((res_cnt_r == CNT_BITS'(1)) && take)))
    else $error("Result buffer overwritten before its last transfer.");

  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tlast && (out_tdata == 8'h00) && !out_tuser[0]))
    else $error("Rejected result is not a single zero byte.");

  a_fend_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_tuser[0]) |=> !in_frame_r || $past(proc))
    else $error("Frame still open after its end byte.");
`endif

endmodule

FILE: tb/tb_stx_etx_frame_encoder_crc16.sv
// Self-checking testbench for the STX/ETX frame encoder with CRC-16 trailer.
`timescale 1ns / 1ps

module tb_stx_etx_frame_encoder_crc16
  import stxenc_pkg::*;
;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic [15:0] len;
  } pay_item_t;

  typedef struct {
    logic [7:0] byte_v;
    logic       last;
    logic       fend;
    logic       rej;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] data_byte, [23:8] frame_len
  logic [0:0]  in_tuser = '0;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;       // [0] frame_end, [1] rejected
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pay_item_t  pay_q[$];
  wire_byte_t wire_q[$];

  logic [7:0]  cfg_sof = START_BYTE_RST;
  logic [7:0]  cfg_eof = END_BYTE_RST;
  logic [15:0] cfg_max = MAX_PAYLOAD_RST;
  logic        frm_open = 1'b0;
  logic [15:0] frm_remaining = '0;
  logic [15:0] frm_crc = CRC_INIT;

  int in_idle_pct = 37;
  int out_idle_pct = 37;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_frames = 0;
  int n_rej = 0;
  int n_settings = 1;

  stx_etx_frame_encoder_crc16 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                 input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[15] ^ data[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic push_wire(input logic [7:0] b, input logic fend, input logic rej);
    wire_byte_t w;
    w.byte_v = b;
    w.last = 1'b0;
    w.fend = fend;
    w.rej = rej;
    wire_q.push_back(w);
  endtask

  task automatic encode_item(input logic [7:0] data, input logic start,
                             input logic [15:0] len);
    if (!frm_open) begin
      if (!start) begin
        return;
      end
      if (len == 16'd0 || len > cfg_max) begin
        push_wire(8'h00, 1'b0, 1'b1);
        wire_q[wire_q.size() - 1].last = 1'b1;
        return;
      end
      push_wire(cfg_sof, 1'b0, 1'b0);
      push_wire(len[7:0], 1'b0, 1'b0);
      push_wire(len[15:8], 1'b0, 1'b0);
      push_wire(8'h00, 1'b0, 1'b0);
      push_wire(8'h00, 1'b0, 1'b0);
      frm_open = 1'b1;
      frm_remaining = len;
      frm_crc = CRC_INIT;
    end
    push_wire(data, 1'b0, 1'b0);
    frm_crc = crc_ccitt_step(frm_crc, data);
    frm_remaining = frm_remaining - 16'd1;
    if (frm_remaining == 16'd0) begin
      push_wire(frm_crc[7:0], 1'b0, 1'b0);
      push_wire(frm_crc[15:8], 1'b0, 1'b0);
      push_wire(cfg_eof, 1'b1, 1'b0);
      frm_open = 1'b0;
      frm_crc = CRC_INIT;
    end
    wire_q[wire_q.size() - 1].last = 1'b1;
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        void'(pay_q.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pay_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {pay_q[0].len, pay_q[0].data};
          in_tuser <= pay_q[0].start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with random stalls and requested long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_tready <= 1'b0;
      hold_seen <= hold_seen + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    wire_byte_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        n_in++;
        encode_item(in_tdata[7:0], in_tuser[0], in_tdata[23:8]);
      end
      if (out_tvalid && out_tready) begin
        n_out++;
        if (out_tuser[0]) n_frames++;
        if (out_tuser[1]) n_rej++;
        if (wire_q.size() == 0) begin
          $error("unexpected result transfer: out_byte %0h", out_tdata);
          errors++;
        end else begin
          w = wire_q.pop_front();
          if (out_tdata !== w.byte_v) begin
            $error("out_byte: expected %0h, actual %0h", w.byte_v, out_tdata);
            errors++;
          end
          if (out_tlast !== w.last) begin
            $error("run_last: expected %0b, actual %0b", w.last, out_tlast);
            errors++;
          end
          if (out_tuser[0] !== w.fend) begin
            $error("frame_end: expected %0b, actual %0b", w.fend, out_tuser[0]);
            errors++;
          end
          if (out_tuser[1] !== w.rej) begin
            $error("rejected: expected %0b, actual %0b", w.rej, out_tuser[1]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_item(input logic [7:0] data, input logic start,
                          input logic [15:0] len);
    pay_item_t it;
    it.data = data;
    it.start = start;
    it.len = len;
    pay_q.push_back(it);
  endtask

  task automatic add_traffic(input int n_items);
    int done;
    int r;
    int lim;
    int flen;
    logic [15:0] rlen;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        add_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
        done++;
      end else if (r < 22 || cfg_max == 16'd0) begin
        if (cfg_max == 16'd0) begin
          rlen = 16'($urandom_range(65535));
        end else if (cfg_max == 16'hFFFF || $urandom_range(3) == 0) begin
          rlen = 16'd0;
        end else begin
          rlen = 16'($urandom_range(int'(cfg_max) + 1, 65535));
        end
        add_item(8'($urandom_range(255)), 1'b1, rlen);
        done++;
      end else begin
        lim = (cfg_max < 6) ? int'(cfg_max) : 6;
        if ($urandom_range(7) == 0) begin
          lim = (cfg_max < 40) ? int'(cfg_max) : 40;
        end
        flen = $urandom_range(1, lim);
        add_item(8'($urandom_range(255)), 1'b1, 16'(flen));
        for (int k = 1; k < flen; k++) begin
          add_item(8'($urandom_range(255)), ($urandom_range(7) == 0),
                   16'($urandom_range(65535)));
        end
        done += flen;
      end
    end
  endtask

  task automatic wait_drained();
    while (pay_q.size() != 0 || in_tvalid || wire_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START_BYTE:  cfg_sof = value[7:0];
      REG_END_BYTE:    cfg_eof = value[7:0];
      REG_MAX_PAYLOAD: cfg_max = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] sof, input logic [7:0] eof,
                          input logic [15:0] maxlen);
    write_reg(REG_START_BYTE, {24'h0, sof});
    write_reg(REG_END_BYTE, {24'h0, eof});
    write_reg(REG_MAX_PAYLOAD, {16'h0, maxlen});
    n_settings++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_item(8'h5A, 1'b0, 16'h0000);
    add_item(8'h00, 1'b1, 16'd1);
    add_item(8'hFF, 1'b1, 16'd3);
    add_item(8'hA5, 1'b1, 16'hFFFF);
    add_item(8'h80, 1'b0, 16'h0000);
    add_item(8'h11, 1'b1, 16'd0);
    add_item(8'h22, 1'b1, 16'd4097);
    add_item(8'hFF, 1'b1, 16'hFFFF);
    add_item(8'h01, 1'b1, 16'd2);
    add_item(8'hFE, 1'b0, 16'h1234);
    add_item(8'h33, 1'b0, 16'hFFFF);
    add_item(8'h7F, 1'b1, 16'd5);
    add_item(8'h01, 1'b0, 16'h0000);
    add_item(8'h02, 1'b1, 16'hAAAA);
    add_item(8'h04, 1'b0, 16'h5555);
    add_item(8'h08, 1'b0, 16'h0000);
    add_traffic(60);
    wait_drained();

    set_regs(8'h00, 8'hFF, 16'd1);
    add_item(8'hC3, 1'b1, 16'd1);
    add_item(8'h3C, 1'b1, 16'd2);
    add_traffic(30);
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct = 0;
    set_regs(8'hFF, 8'h00, 16'hFFFF);
    add_traffic(80);
    wait_drained();

    in_idle_pct = 37;
    out_idle_pct = 37;
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
             16'($urandom_range(2, 200)));
    add_traffic(80);
    hold_req++;
    wait_drained();

    set_regs(8'h7E, 8'h7D, 16'd0);
    add_traffic(10);
    wait_drained();

    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), MAX_PAYLOAD_RST);
    add_traffic(70);
    wait_drained();

    repeat (10) @(posedge clk);
    if (wire_q.size() != 0) begin
      $error("%0d expected results never arrived", wire_q.size());
      errors++;
    end
    $display("Run covered %0d input transfers and %0d result transfers under %0d settings,",
             n_in, n_out, n_settings);
    $display("with %0d closed frames and %0d rejected starts.", n_frames, n_rej);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/stxenc_pkg.sv
rtl/stx_etx_frame_encoder_crc16.sv
tb/tb_stx_etx_frame_encoder_crc16.sv
